// ----- rtl/core/utsc_pkg.sv -----
// package for the uri template syntax checker
// holds the parse phase type, the byte class record and the status codes
// no dependencies
package utsc_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   typedef enum logic [3:0] {
      PH_LIT      = 4'd0,
      PH_LIT_PCT  = 4'd1,
      PH_LIT_UTF8 = 4'd2,
      PH_OPEN     = 4'd3,
      PH_VSTART   = 4'd4,
      PH_NAME     = 4'd5,
      PH_DOT      = 4'd6,
      PH_VAR_PCT  = 4'd7,
      PH_COLON    = 4'd8,
      PH_DIGITS   = 4'd9,
      PH_EXPLODE  = 4'd10
   } phase_type;

   localparam logic [1:0] STATUS_FINE    = 2'd0;
   localparam logic [1:0] STATUS_ERROR   = 2'd1;
   localparam logic [1:0] STATUS_VALID   = 2'd2;
   localparam logic [1:0] STATUS_INVALID = 2'd3;

   localparam logic [2:0] BOUNDS_80_BF = 3'd0;
   localparam logic [2:0] BOUNDS_A0_BF = 3'd1;
   localparam logic [2:0] BOUNDS_80_9F = 3'd2;
   localparam logic [2:0] BOUNDS_90_BF = 3'd3;
   localparam logic [2:0] BOUNDS_80_8F = 3'd4;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COMMA  = 8'h2C;

   typedef struct packed {
      logic       end_mark;
      logic       lbrace;
      logic       rbrace;
      logic       pct;
      logic       star;
      logic       colon;
      logic       dot;
      logic       comma;
      logic       dig;
      logic       dig19;
      logic       hexd;
      logic       vchar;
      logic       op;
      logic       lit;
      logic [1:0] lead_len;
      logic [2:0] lead_bounds;
      logic       cont_80_bf;
      logic       cont_a0_bf;
      logic       cont_80_9f;
      logic       cont_90_bf;
      logic       cont_80_8f;
   } class_type;

endpackage

// ----- rtl/core/utsc_front.sv -----
// front end: accepts a beat and reduces the byte to a class record
// depends on utsc_pkg
module utsc_front (
   input  logic                req_push,
   input  logic                req_action,
   input  logic [7:0]          req_byte_in,
   input  logic                q_full,
   output logic                q_write,
   output utsc_pkg::class_type q_item
);
   import utsc_pkg::*;

   logic [7:0] c;
   logic       is_dig;

   assign c      = req_byte_in;
   assign is_dig = (c >= 8'h30) && (c <= 8'h39);
   assign q_write = req_push && !q_full;

   always_comb begin
      q_item          = '0;
      q_item.end_mark = req_action;
      q_item.lbrace   = (c == CH_LBRACE);
      q_item.rbrace   = (c == CH_RBRACE);
      q_item.pct      = (c == CH_PCT);
      q_item.star     = (c == CH_STAR);
      q_item.colon    = (c == CH_COLON);
      q_item.dot      = (c == CH_DOT);
      q_item.comma    = (c == CH_COMMA);
      q_item.dig      = is_dig;
      q_item.dig19    = (c >= 8'h31) && (c <= 8'h39);
      q_item.hexd     = is_dig || ((c >= 8'h41) && (c <= 8'h46))
                        || ((c >= 8'h61) && (c <= 8'h66));
      q_item.vchar    = is_dig || ((c >= 8'h41) && (c <= 8'h5A))
                        || ((c >= 8'h61) && (c <= 8'h7A)) || (c == 8'h5F);
      q_item.op       = (c == 8'h2B) || (c == 8'h23) || (c == 8'h2E) || (c == 8'h2F)
                        || (c == 8'h3B) || (c == 8'h3F) || (c == 8'h26) || (c == 8'h3D)
                        || (c == 8'h2C) || (c == 8'h21) || (c == 8'h40) || (c == 8'h7C);
      q_item.lit      = (c == 8'h21) || (c == 8'h23) || (c == 8'h24) || (c == 8'h26)
                        || ((c >= 8'h28) && (c <= 8'h3B)) || (c == 8'h3D)
                        || ((c >= 8'h3F) && (c <= 8'h5B)) || (c == 8'h5D)
                        || (c == 8'h5F) || ((c >= 8'h61) && (c <= 8'h7A))
                        || (c == 8'h7E);
      q_item.cont_80_bf = (c >= 8'h80) && (c <= 8'hBF);
      q_item.cont_a0_bf = (c >= 8'hA0) && (c <= 8'hBF);
      q_item.cont_80_9f = (c >= 8'h80) && (c <= 8'h9F);
      q_item.cont_90_bf = (c >= 8'h90) && (c <= 8'hBF);
      q_item.cont_80_8f = (c >= 8'h80) && (c <= 8'h8F);
      // utf-8 lead byte, length zero marks a bad lead
      priority if ((c >= 8'hC2) && (c <= 8'hDF)) begin
         q_item.lead_len    = 2'd1;
         q_item.lead_bounds = BOUNDS_80_BF;
      end else if (c == 8'hE0) begin
         q_item.lead_len    = 2'd2;
         q_item.lead_bounds = BOUNDS_A0_BF;
      end else if (c == 8'hED) begin
         q_item.lead_len    = 2'd2;
         q_item.lead_bounds = BOUNDS_80_9F;
      end else if ((c >= 8'hE1) && (c <= 8'hEF)) begin
         q_item.lead_len    = 2'd2;
         q_item.lead_bounds = BOUNDS_80_BF;
      end else if (c == 8'hF0) begin
         q_item.lead_len    = 2'd3;
         q_item.lead_bounds = BOUNDS_90_BF;
      end else if (c == 8'hF4) begin
         q_item.lead_len    = 2'd3;
         q_item.lead_bounds = BOUNDS_80_8F;
      end else if ((c >= 8'hF1) && (c <= 8'hF3)) begin
         q_item.lead_len    = 2'd3;
         q_item.lead_bounds = BOUNDS_80_BF;
      end else begin
         q_item.lead_len    = 2'd0;
         q_item.lead_bounds = BOUNDS_80_BF;
      end
   end

endmodule

// ----- rtl/core/utsc_queue.sv -----
// short queue of class records between front and back
// depends on utsc_pkg
module utsc_queue #(
   parameter int unsigned DEPTH = utsc_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  utsc_pkg::class_type wr_item,
   output logic                full,
   input  logic                rd_en,
   output logic                rd_valid,
   output utsc_pkg::class_type rd_item
);
   import utsc_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   class_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_wr, do_rd;

   assign full     = (count_ff == FULL_CNT);
   assign rd_valid = (count_ff != '0);
   assign rd_item  = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ----- rtl/core/utsc_back.sv -----
// back end: grammar state machine and result register
// depends on utsc_pkg
module utsc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  utsc_pkg::class_type q_item,
   output logic                q_read,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [1:0]          rsp_status
);
   import utsc_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [1:0] hex_left_ff, hex_left_in;
   logic [1:0] utf8_left_ff, utf8_left_in;
   logic [2:0] bounds_ff, bounds_in;
   logic [2:0] digit_count_ff, digit_count_in;
   logic       error_seen_ff, error_seen_in;
   logic       out_valid_ff, out_valid_in;
   logic [1:0] status_ff, status_in;
   logic       step, ok, cont_ok;
   logic [1:0] hex_dec, utf8_dec;
   class_type  it;

   assign it        = q_item;
   assign step      = q_valid && (!out_valid_ff || rsp_pop);
   assign q_read    = step;
   assign rsp_empty = !out_valid_ff;
   assign rsp_status = status_ff;
   assign hex_dec   = hex_left_ff - 1'b1;
   assign utf8_dec  = utf8_left_ff - 1'b1;

   always_comb begin
      unique case (bounds_ff)
         BOUNDS_A0_BF: cont_ok = it.cont_a0_bf;
         BOUNDS_80_9F: cont_ok = it.cont_80_9f;
         BOUNDS_90_BF: cont_ok = it.cont_90_bf;
         BOUNDS_80_8F: cont_ok = it.cont_80_8f;
         default:      cont_ok = it.cont_80_bf;
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      hex_left_in    = hex_left_ff;
      utf8_left_in   = utf8_left_ff;
      bounds_in      = bounds_ff;
      digit_count_in = digit_count_ff;
      ok             = 1'b0;
      unique case (phase_ff)
         PH_LIT: begin
            priority if (it.lbrace) begin
               ok = 1'b1; phase_in = PH_OPEN;
            end else if (it.pct) begin
               ok = 1'b1; hex_left_in = 2'd2; phase_in = PH_LIT_PCT;
            end else if (it.lit) begin
               ok = 1'b1;
            end else if (it.lead_len != 2'd0) begin
               ok = 1'b1; utf8_left_in = it.lead_len; bounds_in = it.lead_bounds;
               phase_in = PH_LIT_UTF8;
            end else begin
               ok = 1'b0;
            end
         end
         PH_LIT_PCT, PH_VAR_PCT: begin
            if (it.hexd) begin
               ok = 1'b1;
               hex_left_in = hex_dec;
               if (hex_dec == 2'd0) begin
                  phase_in = (phase_ff == PH_LIT_PCT) ? PH_LIT : PH_NAME;
               end
            end
         end
         PH_LIT_UTF8: begin
            if (cont_ok) begin
               ok = 1'b1;
               bounds_in = BOUNDS_80_BF;
               utf8_left_in = utf8_dec;
               if (utf8_dec == 2'd0) begin
                  phase_in = PH_LIT;
               end
            end
         end
         PH_OPEN, PH_VSTART, PH_DOT, PH_NAME: begin
            priority if ((phase_ff == PH_OPEN) && it.op) begin
               ok = 1'b1; phase_in = PH_VSTART;
            end else if ((phase_ff == PH_NAME) && it.dot) begin
               ok = 1'b1; phase_in = PH_DOT;
            end else if ((phase_ff == PH_NAME) && it.star) begin
               ok = 1'b1; phase_in = PH_EXPLODE;
            end else if ((phase_ff == PH_NAME) && it.colon) begin
               ok = 1'b1; phase_in = PH_COLON;
            end else if (it.pct) begin
               ok = 1'b1; hex_left_in = 2'd2; phase_in = PH_VAR_PCT;
            end else if (it.vchar) begin
               ok = 1'b1; phase_in = PH_NAME;
            end else if ((phase_ff == PH_NAME) && it.comma) begin
               ok = 1'b1; phase_in = PH_VSTART;
            end else if ((phase_ff == PH_NAME) && it.rbrace) begin
               ok = 1'b1; phase_in = PH_LIT;
            end else begin
               ok = 1'b0;
            end
         end
         PH_COLON: begin
            if (it.dig19) begin
               ok = 1'b1; digit_count_in = 3'd1; phase_in = PH_DIGITS;
            end
         end
         PH_DIGITS, PH_EXPLODE: begin
            priority if ((phase_ff == PH_DIGITS) && it.dig) begin
               if (digit_count_ff < 3'd4) begin
                  ok = 1'b1; digit_count_in = digit_count_ff + 1'b1;
               end
            end else if (it.comma) begin
               ok = 1'b1; phase_in = PH_VSTART;
            end else if (it.rbrace) begin
               ok = 1'b1; phase_in = PH_LIT;
            end else begin
               ok = 1'b0;
            end
         end
         default: ok = 1'b0;
      endcase

      error_seen_in = error_seen_ff;
      out_valid_in  = out_valid_ff;
      status_in     = status_ff;
      if (out_valid_ff && rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (step) begin
         out_valid_in = 1'b1;
         if (it.end_mark) begin
            status_in      = (!error_seen_ff && (phase_ff == PH_LIT)) ? STATUS_VALID
                                                                      : STATUS_INVALID;
            phase_in       = PH_LIT;
            hex_left_in    = '0;
            utf8_left_in   = '0;
            bounds_in      = BOUNDS_80_BF;
            digit_count_in = '0;
            error_seen_in  = 1'b0;
         end else if (error_seen_ff || !ok) begin
            // the first bad byte and the bytes after it leave the state alone
            phase_in       = phase_ff;
            hex_left_in    = hex_left_ff;
            utf8_left_in   = utf8_left_ff;
            bounds_in      = bounds_ff;
            digit_count_in = digit_count_ff;
            error_seen_in  = 1'b1;
            status_in      = STATUS_ERROR;
         end else begin
            status_in      = STATUS_FINE;
         end
      end else begin
         phase_in       = phase_ff;
         hex_left_in    = hex_left_ff;
         utf8_left_in   = utf8_left_ff;
         bounds_in      = bounds_ff;
         digit_count_in = digit_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LIT;
         hex_left_ff    <= '0;
         utf8_left_ff   <= '0;
         bounds_ff      <= BOUNDS_80_BF;
         digit_count_ff <= '0;
         error_seen_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         hex_left_ff    <= hex_left_in;
         utf8_left_ff   <= utf8_left_in;
         bounds_ff      <= bounds_in;
         digit_count_ff <= digit_count_in;
         error_seen_ff  <= error_seen_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (step && it.end_mark) |=> (phase_ff == PH_LIT) && !error_seen_ff)
      else $error("end beat did not return parser to start");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (step && error_seen_ff && !it.end_mark) |=> error_seen_ff && (status_ff == STATUS_ERROR))
      else $error("error flag dropped before end beat");

   a_hex_in_pct: assert property (@(posedge clock) disable iff (reset)
      (hex_left_ff != 2'd0) |-> ((phase_ff == PH_LIT_PCT) || (phase_ff == PH_VAR_PCT)))
      else $error("hex count live outside pct triple");

   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("result lost after step");

endmodule

// ----- rtl/core/uri_template_syntax_checker.sv -----
// top level of the uri template syntax checker
// depends on utsc_pkg, utsc_front, utsc_queue, utsc_back
//
//   channel   ports                                   handshake
//   request   req_action, req_byte_in                 req_push / req_full
//   response  rsp_status                              rsp_empty / rsp_pop
//
// one beat per cycle while rsp_pop holds; each beat gives one response beat
// a request is registered in a queue slot, then in the back end result register
// the back end state update loops through its own registers and sets the rate
// reset is synchronous and returns the parser to the literal phase, queue empty
// a stalled response fills the queue, and req_full rises once it holds QUEUE_DEPTH beats
module uri_template_syntax_checker #(
   parameter int unsigned QUEUE_DEPTH = utsc_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_action,
   input  logic [7:0] req_byte_in,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_status
);
   import utsc_pkg::*;

   logic      q_write, q_read, q_valid;
   class_type q_wr_item, q_rd_item;

   utsc_front u_front (
      .req_push    (req_push),
      .req_action  (req_action),
      .req_byte_in (req_byte_in),
      .q_full      (req_full),
      .q_write     (q_write),
      .q_item      (q_wr_item)
   );

   utsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_write),
      .wr_item  (q_wr_item),
      .full     (req_full),
      .rd_en    (q_read),
      .rd_valid (q_valid),
      .rd_item  (q_rd_item)
   );

   utsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_rd_item),
      .q_read     (q_read),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_status (rsp_status)
   );

endmodule

// ----- test/utsc_status_checker.sv -----
`timescale 1ns / 1ps
// status checker for the uri template syntax checker: predicts each response beat
// from the accepted request beats and compares it with what comes out
// depends on utsc_pkg
module utsc_status_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic       req_action,
   input  logic [7:0] req_byte_in,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [1:0] rsp_status,
   output int         fail_count,
   output int         due_count
);
   import utsc_pkg::*;

   phase_type  phase;
   logic [1:0] hex_due;
   logic [1:0] cont_due;
   logic [2:0] cont_bounds;
   logic [2:0] prefix_digits;
   logic       sticky_err;

   logic [1:0] status_due[$];
   int         mismatches = 0;

   assign fail_count = mismatches;

   function automatic void clear_parser();
      phase         = PH_LIT;
      hex_due       = 2'd0;
      cont_due      = 2'd0;
      cont_bounds   = BOUNDS_80_BF;
      prefix_digits = 3'd0;
      sticky_err    = 1'b0;
   endfunction

   function automatic logic enter_name(input logic [7:0] c);
      if (c == CH_PCT) begin
         hex_due = 2'd2;
         phase   = PH_VAR_PCT;
         return 1'b1;
      end
      if (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F}) begin
         phase = PH_NAME;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic close_spec(input logic [7:0] c);
      if (c == CH_COMMA) begin
         phase = PH_VSTART;
         return 1'b1;
      end
      if (c == CH_RBRACE) begin
         phase = PH_LIT;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic parse_byte(input logic [7:0] c);
      logic in_range;
      case (phase)
         PH_LIT: begin
            if (c == CH_LBRACE) begin
               phase = PH_OPEN;
               return 1'b1;
            end
            if (c == CH_PCT) begin
               hex_due = 2'd2;
               phase   = PH_LIT_PCT;
               return 1'b1;
            end
            if (c < 8'h80)
               return c inside {8'h21, 8'h23, 8'h24, 8'h26, [8'h28:8'h3B], 8'h3D,
                                [8'h3F:8'h5B], 8'h5D, 8'h5F, [8'h61:8'h7A], 8'h7E};
            cont_bounds = BOUNDS_80_BF;
            if (c inside {[8'hC2:8'hDF]}) begin
               cont_due = 2'd1;
            end else if (c == 8'hE0) begin
               cont_due    = 2'd2;
               cont_bounds = BOUNDS_A0_BF;
            end else if (c == 8'hED) begin
               cont_due    = 2'd2;
               cont_bounds = BOUNDS_80_9F;
            end else if (c inside {[8'hE1:8'hEF]}) begin
               cont_due = 2'd2;
            end else if (c == 8'hF0) begin
               cont_due    = 2'd3;
               cont_bounds = BOUNDS_90_BF;
            end else if (c == 8'hF4) begin
               cont_due    = 2'd3;
               cont_bounds = BOUNDS_80_8F;
            end else if (c inside {[8'hF1:8'hF3]}) begin
               cont_due = 2'd3;
            end else begin
               return 1'b0;
            end
            phase = PH_LIT_UTF8;
            return 1'b1;
         end
         PH_LIT_PCT, PH_VAR_PCT: begin
            if (!(c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]}))
               return 1'b0;
            hex_due = hex_due - 2'd1;
            if (hex_due == 2'd0) begin
               if (phase == PH_LIT_PCT)
                  phase = PH_LIT;
               else
                  phase = PH_NAME;
            end
            return 1'b1;
         end
         PH_LIT_UTF8: begin
            case (cont_bounds)
               BOUNDS_A0_BF: in_range = c inside {[8'hA0:8'hBF]};
               BOUNDS_80_9F: in_range = c inside {[8'h80:8'h9F]};
               BOUNDS_90_BF: in_range = c inside {[8'h90:8'hBF]};
               BOUNDS_80_8F: in_range = c inside {[8'h80:8'h8F]};
               default:      in_range = c inside {[8'h80:8'hBF]};
            endcase
            if (!in_range)
               return 1'b0;
            cont_bounds = BOUNDS_80_BF;
            cont_due    = cont_due - 2'd1;
            if (cont_due == 2'd0)
               phase = PH_LIT;
            return 1'b1;
         end
         PH_OPEN: begin
            // + # . / ; ? & = , ! @ |
            if (c inside {8'h2B, 8'h23, 8'h2E, 8'h2F, 8'h3B, 8'h3F, 8'h26, 8'h3D,
                          8'h2C, 8'h21, 8'h40, 8'h7C}) begin
               phase = PH_VSTART;
               return 1'b1;
            end
            return enter_name(c);
         end
         PH_VSTART, PH_DOT:
            return enter_name(c);
         PH_NAME: begin
            if (c == CH_DOT) begin
               phase = PH_DOT;
               return 1'b1;
            end
            if (c == CH_STAR) begin
               phase = PH_EXPLODE;
               return 1'b1;
            end
            if (c == CH_COLON) begin
               phase = PH_COLON;
               return 1'b1;
            end
            if (enter_name(c))
               return 1'b1;
            return close_spec(c);
         end
         PH_COLON: begin
            if (!(c inside {[8'h31:8'h39]}))
               return 1'b0;
            prefix_digits = 3'd1;
            phase         = PH_DIGITS;
            return 1'b1;
         end
         PH_DIGITS: begin
            if (c inside {[8'h30:8'h39]}) begin
               if (prefix_digits >= 3'd4)
                  return 1'b0;
               prefix_digits = prefix_digits + 3'd1;
               return 1'b1;
            end
            return close_spec(c);
         end
         PH_EXPLODE:
            return close_spec(c);
         default:
            return 1'b0;
      endcase
   endfunction

   function automatic logic [1:0] predict_status(input logic act, input logic [7:0] c);
      logic well_formed;
      if (act) begin
         well_formed = !sticky_err && (phase == PH_LIT);
         clear_parser();
         return well_formed ? STATUS_VALID : STATUS_INVALID;
      end
      if (!sticky_err && !parse_byte(c))
         sticky_err = 1'b1;
      return sticky_err ? STATUS_ERROR : STATUS_FINE;
   endfunction

   always @(posedge clock) begin
      logic [1:0] want;
      if (reset) begin
         clear_parser();
         status_due.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (status_due.size() == 0) begin
               $error("status: expected none, actual %0d", rsp_status);
               mismatches++;
            end else begin
               want = status_due.pop_front();
               if (rsp_status !== want) begin
                  $error("status: expected %0d, actual %0d", want, rsp_status);
                  mismatches++;
               end
            end
         end
         if (req_push && !req_full)
            status_due.push_back(predict_status(req_action, req_byte_in));
      end
      due_count <= status_due.size();
   end

endmodule

// ----- test/tb_uri_template_syntax_checker.sv -----
`timescale 1ns / 1ps
// top of the uri template syntax checker testbench: directed and random templates
// with random idling on both channels, verdict from the status checker
// depends on utsc_pkg, uri_template_syntax_checker, utsc_status_checker
module tb_uri_template_syntax_checker;
   import utsc_pkg::*;

   localparam int    CYCLE_LIMIT = 200000;
   localparam int    BEAT_TARGET = 1700;
   localparam int    CALM_AFTER  = 1450;
   localparam string LIT_CHARS   = "!#$&()*+,-./0123456789:;=?@AQZ[]_amz~";
   localparam string HEX_CHARS   = "0123456789abcdefABCDEF";
   localparam string VAR_CHARS   = "azAZ09_qM7";
   localparam string OP_CHARS    = "+#./;?&=,!@|";

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_push    = 1'b0;
   logic       req_action  = 1'b0;
   logic [7:0] req_byte_in = 8'h00;
   logic       rsp_pop     = 1'b0;
   logic       req_full;
   logic       rsp_empty;
   logic [1:0] rsp_status;

   int         fail_count;
   int         due_count;
   int         cycle_count = 0;
   int         beats_sent  = 0;
   int         gap_pct     = 0;
   int         stall_pct   = 0;
   int         stall_left  = 0;
   logic       quiet_tail  = 1'b0;
   logic [7:0] tmpl[$];

   uri_template_syntax_checker dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_action  (req_action),
      .req_byte_in (req_byte_in),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_status  (rsp_status)
   );

   utsc_status_checker status_check (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_action  (req_action),
      .req_byte_in (req_byte_in),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_status  (rsp_status),
      .fail_count  (fail_count),
      .due_count   (due_count)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_uri_template_syntax_checker: done, errors");
         $finish;
      end
   end

   // response side stalls in random bursts
   always @(posedge clock) begin
      if (cycle_count % 64 == 0)
         stall_pct <= $urandom_range(0, 3) * 12;
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_pop    <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 4);
         rsp_pop    <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   function automatic logic [7:0] pick(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function automatic void add_pct();
      tmpl.push_back(CH_PCT);
      tmpl.push_back(pick(HEX_CHARS));
      tmpl.push_back(pick(HEX_CHARS));
   endfunction

   function automatic void build_template();
      int kind;
      int mode;
      int digits;
      int pos;
      repeat ($urandom_range(1, 4)) begin
         kind = $urandom_range(0, 3);
         case (kind)
            0: repeat ($urandom_range(1, 4)) tmpl.push_back(pick(LIT_CHARS));
            1: add_pct();
            2: begin
               mode = $urandom_range(0, 6);
               case (mode)
                  0: tmpl.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                  1: begin
                     tmpl.push_back(8'hE0);
                     tmpl.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                  end
                  2: begin
                     tmpl.push_back(8'hED);
                     tmpl.push_back(8'($urandom_range(8'h80, 8'h9F)));
                  end
                  3: begin
                     tmpl.push_back(8'($urandom_range(8'hE1, 8'hEC)));
                     tmpl.push_back(8'($urandom_range(8'h80, 8'hBF)));
                  end
                  4: begin
                     tmpl.push_back(8'hF0);
                     tmpl.push_back(8'($urandom_range(8'h90, 8'hBF)));
                     tmpl.push_back(8'($urandom_range(8'h80, 8'hBF)));
                  end
                  5: begin
                     tmpl.push_back(8'($urandom_range(8'hF1, 8'hF3)));
                     tmpl.push_back(8'($urandom_range(8'h80, 8'hBF)));
                     tmpl.push_back(8'($urandom_range(8'h80, 8'hBF)));
                  end
                  default: begin
                     tmpl.push_back(8'hF4);
                     tmpl.push_back(8'($urandom_range(8'h80, 8'h8F)));
                     tmpl.push_back(8'($urandom_range(8'h80, 8'hBF)));
                  end
               endcase
               tmpl.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            default: begin
               tmpl.push_back(CH_LBRACE);
               if ($urandom_range(0, 1) == 1)
                  tmpl.push_back(pick(OP_CHARS));
               for (int s = 0; s < $urandom_range(1, 3); s++) begin
                  if (s > 0)
                     tmpl.push_back(CH_COMMA);
                  for (int g = 0; g < $urandom_range(1, 2); g++) begin
                     if (g > 0)
                        tmpl.push_back(CH_DOT);
                     repeat ($urandom_range(1, 3)) begin
                        if ($urandom_range(0, 4) == 0)
                           add_pct();
                        else
                           tmpl.push_back(pick(VAR_CHARS));
                     end
                  end
                  mode = $urandom_range(0, 9);
                  if (mode == 4 || mode == 5) begin
                     tmpl.push_back(CH_STAR);
                  end else if (mode >= 6) begin
                     tmpl.push_back(CH_COLON);
                     digits = (mode == 9) ? 5 : $urandom_range(1, 4);
                     if (mode == 8 && $urandom_range(0, 1) == 1)
                        tmpl.push_back(8'h30);
                     else
                        tmpl.push_back(pick("123456789"));
                     repeat (digits - 1) tmpl.push_back(pick("0123456789"));
                  end
               end
               tmpl.push_back(CH_RBRACE);
            end
         endcase
      end
      // broken sequences: overwrite, cut short or insert a stray byte
      if ($urandom_range(0, 3) == 0) begin
         pos  = $urandom_range(0, tmpl.size() - 1);
         mode = $urandom_range(0, 2);
         case (mode)
            0: tmpl[pos] = 8'($urandom_range(0, 255));
            1: while (tmpl.size() > pos) void'(tmpl.pop_back());
            default: tmpl.insert(pos, 8'($urandom_range(0, 255)));
         endcase
      end
   endfunction

   task automatic send_beat(input logic act, input logic [7:0] b);
      if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_action  <= act;
      req_byte_in <= b;
      do @(posedge clock); while (req_full);
      beats_sent++;
   endtask

   task automatic send_template();
      foreach (tmpl[i]) send_beat(1'b0, tmpl[i]);
      send_beat(1'b1, 8'($urandom_range(0, 255)));
      tmpl.delete();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty template
      send_template();
      // pct triple and the highest four-byte utf-8 sequence
      tmpl = {CH_PCT, 8'h37, 8'h65, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
      send_template();
      // "{+a:99999}" fifth prefix digit
      tmpl = {CH_LBRACE, 8'h2B, 8'h61, CH_COLON, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39,
              CH_RBRACE};
      send_template();
      // unfinished expression
      tmpl = {CH_LBRACE};
      send_template();
      // bad byte then bytes after the error
      tmpl = {8'h00, 8'hFF};
      send_template();
      // "{a:0}" leading zero
      tmpl = {CH_LBRACE, 8'h61, CH_COLON, 8'h30, CH_RBRACE};
      send_template();

      while (beats_sent < BEAT_TARGET) begin
         if (beats_sent > CALM_AFTER)
            quiet_tail <= 1'b1;
         gap_pct = $urandom_range(0, 3) * 10;
         if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 8)) tmpl.push_back(8'($urandom_range(0, 255)));
         else
            build_template();
         send_template();
      end
      req_push <= 1'b0;

      do @(posedge clock); while (due_count != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("tb_uri_template_syntax_checker: done, clean");
      else
         $display("tb_uri_template_syntax_checker: done, errors");
      $finish;
   end

endmodule
